### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tepq_pkg.sv
package tepq_pkg;

  typedef enum logic [1:0] {
    REQ_SCHEDULE   = 2'd0,
    REQ_CANCEL_ONE = 2'd1,
    REQ_CANCEL_ALL = 2'd2,
    REQ_POP        = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_COMPACT,
    ST_APPLY,
    ST_POST
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_APPEND,
    OP_CANCEL_ONE,
    OP_CANCEL_ALL,
    OP_SHIFT,
    OP_SWAP
  } cell_op_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    cell_op_t op;
    logic     phase;
    logic     match_any;
  } cell_ctl_t;

  // Flags that travel with the scan token down the chain.
  typedef struct packed {
    logic valid;
    logic found;
  } tok_flags_t;

endpackage

### rtl/core/tepq_cell.sv
module tepq_cell #(
  parameter int CAPACITY = 16,
  parameter int ID_BITS  = 8,
  parameter int IDX      = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tepq_pkg::cell_ctl_t             ctl,
  input  logic [$clog2(CAPACITY+1)-1:0]   count,
  input  logic [$clog2(CAPACITY)-1:0]     sel_idx,
  input  logic [ID_BITS-1:0]              key_id,
  input  logic [31:0]                     new_time,
  input  logic [31:0]                     left_time,
  input  logic [ID_BITS-1:0]              left_id,
  input  logic [31:0]                     right_time,
  input  logic [ID_BITS-1:0]              right_id,
  output logic [31:0]                     time_o,
  output logic [ID_BITS-1:0]              id_o,
  input  tepq_pkg::tok_flags_t            tok_in_flags,
  input  logic [$clog2(CAPACITY)-1:0]     tok_in_idx,
  input  logic [31:0]                     tok_in_time,
  input  logic [ID_BITS-1:0]              tok_in_id,
  input  logic [$clog2(CAPACITY+1)-1:0]   tok_in_live,
  output tepq_pkg::tok_flags_t            tok_out_flags,
  output logic [$clog2(CAPACITY)-1:0]     tok_out_idx,
  output logic [31:0]                     tok_out_time,
  output logic [ID_BITS-1:0]              tok_out_id,
  output logic [$clog2(CAPACITY+1)-1:0]   tok_out_live
);

  localparam int IdxW = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam logic [IdxW-1:0] MyIdx  = IdxW'(IDX);
  localparam logic [CntW-1:0] MyPos  = CntW'(IDX);
  localparam logic [CntW-1:0] MyNext = CntW'(IDX + 1);
  localparam logic            MyOdd  = 1'(IDX % 2);
  localparam logic            HasLeft = (IDX > 0);

  logic [31:0]          time_r, time_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  tepq_pkg::tok_flags_t flags_r, flags_nxt;
  logic [IdxW-1:0]      idx_r, idx_nxt;
  logic [31:0]          btime_r, btime_nxt;
  logic [ID_BITS-1:0]   bid_r, bid_nxt;
  logic [CntW-1:0]      live_r, live_nxt;

  logic        in_use;
  logic        pair_right;
  logic        take_right;
  logic        take_left;
  logic        consider;
  logic        earlier;
  logic [63:0] my_key;
  logic [63:0] best_key;
  logic [63:0] diff;

  assign in_use     = (MyPos < count);
  assign pair_right = (MyOdd == ctl.phase);
  // A swap pair moves a live entry down over a cancelled one, so live
  // entries keep their order while cancelled ones drift to the top.
  assign take_right = pair_right && (MyNext < count) && (id_r == '0) && (right_id != '0);
  assign take_left  = !pair_right && HasLeft && in_use && (left_id == '0) && (id_r != '0);

  always_comb begin
    time_nxt = time_r;
    id_nxt   = id_r;
    unique case (ctl.op)
      tepq_pkg::OP_NONE: begin
      end
      tepq_pkg::OP_APPEND: begin
        if (MyPos == count) begin
          time_nxt = new_time;
          id_nxt   = key_id;
        end
      end
      tepq_pkg::OP_CANCEL_ONE: begin
        if (MyIdx == sel_idx) begin
          id_nxt = '0;
        end
      end
      tepq_pkg::OP_CANCEL_ALL: begin
        if (in_use && (id_r == key_id)) begin
          id_nxt = '0;
        end
      end
      tepq_pkg::OP_SHIFT: begin
        if (MyIdx >= sel_idx) begin
          time_nxt = right_time;
          id_nxt   = right_id;
        end
      end
      tepq_pkg::OP_SWAP: begin
        if (take_right) begin
          time_nxt = right_time;
          id_nxt   = right_id;
        end else if (take_left) begin
          time_nxt = left_time;
          id_nxt   = left_id;
        end
      end
      default: begin
      end
    endcase
  end

  // The token carries the best entry seen so far; this cell replaces it when
  // none is held yet or its key is strictly earlier, by a wrapping compare.
  assign my_key   = {time_r, 32'(id_r)};
  assign best_key = {tok_in_time, 32'(tok_in_id)};
  assign diff     = my_key - best_key;
  assign earlier  = diff[63];
  assign consider = in_use && (ctl.match_any || (id_r == key_id));

  always_comb begin
    flags_nxt.valid = tok_in_flags.valid;
    flags_nxt.found = tok_in_flags.found;
    idx_nxt         = tok_in_idx;
    btime_nxt       = tok_in_time;
    bid_nxt         = tok_in_id;
    live_nxt        = tok_in_live + CntW'(in_use && (id_r != '0));
    if (consider && (!tok_in_flags.found || earlier)) begin
      flags_nxt.found = 1'b1;
      idx_nxt         = MyIdx;
      btime_nxt       = time_r;
      bid_nxt         = id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    time_r  <= time_nxt;
    id_r    <= id_nxt;
    idx_r   <= idx_nxt;
    btime_r <= btime_nxt;
    bid_r   <= bid_nxt;
    live_r  <= live_nxt;
  end

  assign time_o        = time_r;
  assign id_o          = id_r;
  assign tok_out_flags = flags_r;
  assign tok_out_idx   = idx_r;
  assign tok_out_time  = btime_r;
  assign tok_out_id    = bid_r;
  assign tok_out_live  = live_r;

endmodule

### rtl/core/timed_event_priority_queue_unit.sv
// Timed event priority queue with lazy deletion.
// A request is a transaction taken when start is high and busy is low:
// in_req_type selects schedule, cancel one id, cancel every matching id, or
// pop the earliest entry; in_event_time and in_event_id carry its operands.
// Each request returns exactly one result, shown for one cycle with
// out_strobe; the receiver cannot hold it off. Entries live in a row of
// CAPACITY cells in arrival order, and a scan token walks the row one cell
// per cycle to find the earliest entry. A schedule with room left appends
// and then scans once; cancel, cancel all and pop scan, apply and scan
// again. A schedule into a full store scans, runs a compaction pass that
// moves cancelled entries to the top and drops them, then appends, or
// reports overflow, and scans. busy stays high from acceptance until the
// result cycle, so one request is in flight at a time. Reset empties the
// store; entry contents are not cleared because only positions below the
// stored count are ever used.
module timed_event_priority_queue_unit #(
  parameter int CAPACITY = 16,
  parameter int ID_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_event_time,
  input  logic [7:0]  in_event_id,
  output logic        out_strobe,
  output logic        out_success,
  output logic        out_overflow,
  output logic [7:0]  out_popped_id,
  output logic [31:0] out_next_time,
  output logic        out_is_empty,
  output logic [4:0]  out_stored_count
);

  localparam int IdxW = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);

  tepq_pkg::state_t    state_r, state_nxt;
  tepq_pkg::req_type_t req_r, req_nxt;
  logic [31:0]         ev_time_r, ev_time_nxt;
  logic [ID_BITS-1:0]  ev_id_r, ev_id_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  logic                launch_r, launch_nxt;
  logic [IdxW-1:0]     round_r, round_nxt;
  logic                res_found_r, res_found_nxt;
  logic [IdxW-1:0]     res_idx_r, res_idx_nxt;
  logic [ID_BITS-1:0]  res_id_r, res_id_nxt;
  logic [CntW-1:0]     res_live_r, res_live_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  logic                success_r, success_nxt;
  logic                overflow_r, overflow_nxt;
  logic [7:0]          popped_r, popped_nxt;
  logic [31:0]         next_time_r, next_time_nxt;
  logic                empty_r, empty_nxt;
  logic [4:0]          stored_r, stored_nxt;

  tepq_pkg::cell_ctl_t ctl;

  logic [31:0]          cell_time [CAPACITY];
  logic [ID_BITS-1:0]   cell_id   [CAPACITY];
  tepq_pkg::tok_flags_t tok_flags [CAPACITY+1];
  logic [IdxW-1:0]      tok_idx   [CAPACITY+1];
  logic [31:0]          tok_time  [CAPACITY+1];
  logic [ID_BITS-1:0]   tok_id    [CAPACITY+1];
  logic [CntW-1:0]      tok_live  [CAPACITY+1];

  // A fresh token enters the first cell in the cycle after a scan is launched.
  assign tok_flags[0].valid = launch_r;
  assign tok_flags[0].found = 1'b0;
  assign tok_idx[0]         = '0;
  assign tok_time[0]        = '0;
  assign tok_id[0]          = '0;
  assign tok_live[0]        = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [31:0]        lt;
    logic [ID_BITS-1:0] lid;
    logic [31:0]        rt;
    logic [ID_BITS-1:0] rid;

    if (g == 0) begin : g_first
      assign lt  = '0;
      assign lid = '0;
    end else begin : g_inner_l
      assign lt  = cell_time[g-1];
      assign lid = cell_id[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign rt  = '0;
      assign rid = '0;
    end else begin : g_inner_r
      assign rt  = cell_time[g+1];
      assign rid = cell_id[g+1];
    end

    tepq_cell #(
      .CAPACITY (CAPACITY),
      .ID_BITS  (ID_BITS),
      .IDX      (g)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl),
      .count         (count_r),
      .sel_idx       (res_idx_r),
      .key_id        (ev_id_r),
      .new_time      (ev_time_r),
      .left_time     (lt),
      .left_id       (lid),
      .right_time    (rt),
      .right_id      (rid),
      .time_o        (cell_time[g]),
      .id_o          (cell_id[g]),
      .tok_in_flags  (tok_flags[g]),
      .tok_in_idx    (tok_idx[g]),
      .tok_in_time   (tok_time[g]),
      .tok_in_id     (tok_id[g]),
      .tok_in_live   (tok_live[g]),
      .tok_out_flags (tok_flags[g+1]),
      .tok_out_idx   (tok_idx[g+1]),
      .tok_out_time  (tok_time[g+1]),
      .tok_out_id    (tok_id[g+1]),
      .tok_out_live  (tok_live[g+1])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    ev_time_nxt    = ev_time_r;
    ev_id_nxt      = ev_id_r;
    count_nxt      = count_r;
    launch_nxt     = 1'b0;
    round_nxt      = round_r;
    res_found_nxt  = res_found_r;
    res_idx_nxt    = res_idx_r;
    res_id_nxt     = res_id_r;
    res_live_nxt   = res_live_r;
    out_strobe_nxt = 1'b0;
    success_nxt    = success_r;
    overflow_nxt   = overflow_r;
    popped_nxt     = popped_r;
    next_time_nxt  = next_time_r;
    empty_nxt      = empty_r;
    stored_nxt     = stored_r;

    ctl.op        = tepq_pkg::OP_NONE;
    ctl.phase     = round_r[0];
    // Only the first scan of a cancel request matches on id; every other scan takes any entry.
    ctl.match_any = !((state_r == tepq_pkg::ST_PRE) &&
                      ((req_r == tepq_pkg::REQ_CANCEL_ONE) ||
                       (req_r == tepq_pkg::REQ_CANCEL_ALL)));

    unique case (state_r)
      tepq_pkg::ST_IDLE: begin
        if (start) begin
          req_nxt     = tepq_pkg::req_type_t'(in_req_type);
          ev_time_nxt = in_event_time;
          ev_id_nxt   = ID_BITS'(in_event_id);
          if ((tepq_pkg::req_type_t'(in_req_type) == tepq_pkg::REQ_SCHEDULE) &&
              (count_r < CntW'(CAPACITY))) begin
            state_nxt = tepq_pkg::ST_APPLY;
          end else begin
            state_nxt  = tepq_pkg::ST_PRE;
            launch_nxt = 1'b1;
          end
        end
      end
      tepq_pkg::ST_PRE: begin
        if (tok_flags[CAPACITY].valid) begin
          res_found_nxt = tok_flags[CAPACITY].found;
          res_idx_nxt   = tok_idx[CAPACITY];
          res_id_nxt    = tok_id[CAPACITY];
          res_live_nxt  = tok_live[CAPACITY];
          if (req_r == tepq_pkg::REQ_SCHEDULE) begin
            round_nxt = '0;
            state_nxt = tepq_pkg::ST_COMPACT;
          end else begin
            state_nxt = tepq_pkg::ST_APPLY;
          end
        end
      end
      tepq_pkg::ST_COMPACT: begin
        ctl.op    = tepq_pkg::OP_SWAP;
        round_nxt = round_r + IdxW'(1);
        if (round_r == IdxW'(CAPACITY - 1)) begin
          count_nxt = res_live_r;
          state_nxt = tepq_pkg::ST_APPLY;
        end
      end
      tepq_pkg::ST_APPLY: begin
        success_nxt  = 1'b0;
        overflow_nxt = 1'b0;
        popped_nxt   = '0;
        case (req_r)
          tepq_pkg::REQ_SCHEDULE: begin
            if (count_r < CntW'(CAPACITY)) begin
              ctl.op      = tepq_pkg::OP_APPEND;
              count_nxt   = count_r + CntW'(1);
              success_nxt = 1'b1;
            end else begin
              overflow_nxt = 1'b1;
            end
          end
          tepq_pkg::REQ_CANCEL_ONE: begin
            if (res_found_r) begin
              ctl.op      = tepq_pkg::OP_CANCEL_ONE;
              success_nxt = 1'b1;
            end
          end
          tepq_pkg::REQ_CANCEL_ALL: begin
            if (res_found_r) begin
              ctl.op      = tepq_pkg::OP_CANCEL_ALL;
              success_nxt = 1'b1;
            end
          end
          tepq_pkg::REQ_POP: begin
            if (res_found_r) begin
              ctl.op      = tepq_pkg::OP_SHIFT;
              popped_nxt  = 8'(res_id_r);
              count_nxt   = count_r - CntW'(1);
              success_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
        launch_nxt = 1'b1;
        state_nxt  = tepq_pkg::ST_POST;
      end
      tepq_pkg::ST_POST: begin
        if (tok_flags[CAPACITY].valid) begin
          out_strobe_nxt = 1'b1;
          next_time_nxt  = tok_flags[CAPACITY].found ? tok_time[CAPACITY] : 32'd0;
          empty_nxt      = (count_r == '0);
          stored_nxt     = 5'(count_r);
          state_nxt      = tepq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tepq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tepq_pkg::ST_IDLE;
      count_r      <= '0;
      launch_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      launch_r     <= launch_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    ev_time_r   <= ev_time_nxt;
    ev_id_r     <= ev_id_nxt;
    round_r     <= round_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    res_id_r    <= res_id_nxt;
    res_live_r  <= res_live_nxt;
    success_r   <= success_nxt;
    overflow_r  <= overflow_nxt;
    popped_r    <= popped_nxt;
    next_time_r <= next_time_nxt;
    empty_r     <= empty_nxt;
    stored_r    <= stored_nxt;
  end

  assign busy             = (state_r != tepq_pkg::ST_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_success      = success_r;
  assign out_overflow     = overflow_r;
  assign out_popped_id    = popped_r;
  assign out_next_time    = next_time_r;
  assign out_is_empty     = empty_r;
  assign out_stored_count = stored_r;

endmodule

### rtl/core/tepq_checker.sv
`include "assert_macros.svh"

module tepq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic        out_success,
  input logic        out_overflow,
  input logic [31:0] out_next_time,
  input logic        out_is_empty,
  input logic [4:0]  out_stored_count
);

  logic accepted;

  assign accepted = start && !busy;

  `ASSERT_NEXT(a_accept_busy, clk, rst_n, accepted, busy, "accepted transaction did not raise busy")
  `ASSERT_SAME(a_done_strobe, clk, rst_n, $fell(busy), out_strobe, "busy fell without a result")
  `ASSERT_NEXT(a_single_strobe, clk, rst_n, out_strobe, !out_strobe, "result strobe lasted two cycles")
  `ASSERT_SAME(a_flags_excl, clk, rst_n, out_strobe, !(out_success && out_overflow), "success and overflow both set")
  `ASSERT_SAME(a_empty_view, clk, rst_n, out_strobe && out_is_empty, (out_next_time == 32'd0) && (out_stored_count == 5'd0), "empty store reports entries")

endmodule

bind timed_event_priority_queue_unit tepq_checker u_tepq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_success      (out_success),
  .out_overflow     (out_overflow),
  .out_next_time    (out_next_time),
  .out_is_empty     (out_is_empty),
  .out_stored_count (out_stored_count)
);
